### sv/tch_pkg.sv
// ---------------------------------------------------------------------------
// tch_pkg: shared types and constants for the ClientHello parser
// Parse phases, status codes, register indexes and payload structs.
// ---------------------------------------------------------------------------
package tch_pkg;

	localparam int unsigned MaxMessageBytesDefault = 65536;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RETRY     = 3'd1;
	localparam logic [2:0] ST_DECODE    = 3'd2;
	localparam logic [2:0] ST_HS_FAIL   = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;
	localparam logic [2:0] ST_WRONG_TYP = 3'd5;

	localparam logic [2:0] REG_CIPHER_A = 3'd0;
	localparam logic [2:0] REG_CIPHER_B = 3'd1;
	localparam logic [2:0] REG_CIPHER_C = 3'd2;
	localparam logic [2:0] REG_SIGALG_A = 3'd3;
	localparam logic [2:0] REG_SIGALG_B = 3'd4;
	localparam logic [2:0] REG_SIGALG_C = 3'd5;
	localparam logic [2:0] REG_GROUP    = 3'd6;
	localparam logic [2:0] REG_VERSION  = 3'd7;

	localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
	localparam logic [15:0] EXT_GROUPS      = 16'd10;
	localparam logic [15:0] EXT_SIGALGS     = 16'd13;
	localparam logic [15:0] EXT_KEY_SHARE   = 16'd40;
	localparam logic [15:0] EXT_VERSIONS    = 16'd43;
	localparam logic [15:0] EXT_COOKIE      = 16'd44;

	localparam logic [7:0]  RANDOM_BYTES = 8'd32;
	localparam logic [7:0]  SID_MAX      = 8'd32;
	localparam logic [15:0] LIST2_MAX    = 16'd65534;
	localparam logic [15:0] LIST1_MAX    = 16'd254;

	typedef enum logic [4:0] {
		PH_TYPE, PH_LEN, PH_VER, PH_RANDOM, PH_SIDLEN, PH_SID, PH_CSLEN, PH_CS,
		PH_COMPLEN, PH_COMPMETH, PH_EXTLEN, PH_EXTTYPE, PH_EXTDLEN,
		PH_SKIPEXT, PH_SN_LLEN, PH_SN_TYPE, PH_SN_NLEN, PH_SN_NAME,
		PH_LIST_LEN2, PH_LIST_LEN1, PH_LIST_ITEM, PH_KS_LEN, PH_KS_GROUP,
		PH_KS_KLEN, PH_KS_DATA, PH_EXT_END, PH_DRAIN, PH_DONE, PH_SINK
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] chosen_cipher;
		logic [15:0] chosen_group;
		logic [15:0] chosen_sigalg;
		logic [15:0] share_group;
		logic [15:0] share_offset;
		logic [15:0] share_length;
		logic [15:0] name_offset;
		logic [15:0] name_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] cipher_a;
		logic [15:0] cipher_b;
		logic [15:0] cipher_c;
		logic [15:0] sigalg_a;
		logic [15:0] sigalg_b;
		logic [15:0] sigalg_c;
		logic [15:0] group;
		logic [15:0] version;
	} cfg_t;

endpackage

### sv/tch_stream_if.sv
// ---------------------------------------------------------------------------
// tch_stream_if: valid/ready channel
// Carries one payload per transaction.
// ---------------------------------------------------------------------------
interface tch_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/tls_client_hello_parser.sv
// ---------------------------------------------------------------------------
// tls_client_hello_parser: streaming ClientHello parser
// in_ch carries one message byte per transaction (data_byte, last_byte).
// out_ch carries one result per message, on the transaction of last_byte:
// status plus selected cipher/group/sigalg, key share and host name spans.
// Bytes are registered in an input stage; the parse logic then updates its
// state and, for a last byte, loads the output register. The input stage
// takes one byte per cycle while in_ch is not back-pressured.
// The input stage advances whenever the output register is empty or being
// drained, so a stalled receiver back-pressures in_ch only once a result
// is waiting and another last byte is ready to finish.
// Reset clears the parse state, loads the register defaults and empties
// both stages. The user must make configuration writes (cfg_we/cfg_index/
// cfg_data) only while no message is in progress; nothing checks this.
// ---------------------------------------------------------------------------
module tls_client_hello_parser
	import tch_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MaxMessageBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	tch_stream_if.sink  in_ch,
	tch_stream_if.source out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_q;
	logic      res_valid_q;
	logic      adv;

	tch_cfg_regs u_regs (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg
	);

	assign adv = valid_s1 && (!item_s1.last_byte || !res_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	tch_parser_core #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_core (
		.clk, .arst_n, .cfg, .step(adv), .item(item_s1), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) item_s1 <= in_ch.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last_byte) res_q <= res;
	end

	assign out_ch.valid   = res_valid_q;
	assign out_ch.payload = res_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_ch.ready) |-> !(adv && item_s1.last_byte))
		else $error("result overwritten while stalled");
	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last_byte) |=> res_valid_q)
		else $error("missing result after last byte");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.status <= ST_WRONG_TYP))
		else $error("status out of range");
`endif
endmodule

### sv/tch_cfg_regs.sv
// ---------------------------------------------------------------------------
// tch_cfg_regs: configuration register file
// Eight 16-bit candidate registers, written by index.
// ---------------------------------------------------------------------------
module tch_cfg_regs
	import tch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cipher_a <= 16'd4865;
			cfg_q.cipher_b <= 16'd4866;
			cfg_q.cipher_c <= 16'd4867;
			cfg_q.sigalg_a <= 16'd1025;
			cfg_q.sigalg_b <= 16'd1027;
			cfg_q.sigalg_c <= 16'd2052;
			cfg_q.group    <= 16'd23;
			cfg_q.version  <= 16'h7f16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CIPHER_A: cfg_q.cipher_a <= cfg_data;
				REG_CIPHER_B: cfg_q.cipher_b <= cfg_data;
				REG_CIPHER_C: cfg_q.cipher_c <= cfg_data;
				REG_SIGALG_A: cfg_q.sigalg_a <= cfg_data;
				REG_SIGALG_B: cfg_q.sigalg_b <= cfg_data;
				REG_SIGALG_C: cfg_q.sigalg_c <= cfg_data;
				REG_GROUP:    cfg_q.group    <= cfg_data;
				REG_VERSION:  cfg_q.version  <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

### sv/tch_parser_core.sv
// ---------------------------------------------------------------------------
// tch_parser_core: byte-at-a-time ClientHello parser state
// Updates the parse state per accepted byte and forms the result on the
// last byte of a message.
// ---------------------------------------------------------------------------
module tch_parser_core
	import tch_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MaxMessageBytesDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t result
);
	localparam logic [24:0] MaxBody = 25'(MAX_MESSAGE_BYTES - 4);

	phase_t      ph_q, ph;
	logic [15:0] pos_q, pos;
	logic [23:0] mrem_q, mrem;
	logic [15:0] frem_q, frem;
	logic [15:0] erem_q, erem;
	logic [15:0] irem_q, irem;
	logic [15:0] kind_q, kind;
	logic [7:0]  wsh_q, wsh;
	logic        half_q, half;
	logic [1:0]  seen_q, seen;
	logic [5:0]  got_q, got;
	logic [2:0]  err_q, err;
	logic [15:0] pk0_q, pk1_q, pk2_q, pk3_q, pk0, pk1, pk2, pk3;
	logic [15:0] sp0_q, sp1_q, sp2_q, sp3_q, sp0, sp1, sp2, sp3;

	always_comb begin
		logic [7:0]  b;
		logic        wok;
		logic [15:0] w;
		logic [23:0] mr;
		logic [15:0] wp1;
		logic [1:0]  tgt;
		logic [5:0]  tbit;
		logic        hit;
		logic [2:0]  status;
		logic        fields;
		b = item.data_byte;
		ph = ph_q; pos = pos_q; mrem = mrem_q; frem = frem_q; erem = erem_q;
		irem = irem_q; kind = kind_q; wsh = wsh_q; half = half_q; seen = seen_q;
		got = got_q; err = err_q;
		pk0 = pk0_q; pk1 = pk1_q; pk2 = pk2_q; pk3 = pk3_q;
		sp0 = sp0_q; sp1 = sp1_q; sp2 = sp2_q; sp3 = sp3_q;
		w = {wsh_q, b};
		wok = half_q;
		mr = mrem_q - 24'd1;
		wp1 = pos_q + 16'd1;
		tgt = (kind_q == EXT_GROUPS) ? 2'd1 : (kind_q == EXT_SIGALGS) ? 2'd2 : 2'd3;
		tbit = (tgt == 2'd1) ? 6'd2 : (tgt == 2'd2) ? 6'd4 : 6'd8;
		hit = 1'b0;
		status = ST_OK;
		fields = 1'b0;

		case (ph_q)
			PH_TYPE: begin
				if (b != 8'd1) err = ST_WRONG_TYP;
				mrem = '0; frem = 16'd3; ph = PH_LEN;
			end
			PH_LEN: begin
				mrem = {mrem_q[15:0], b};
				frem = frem_q - 16'd1;
				if (frem == 16'd0) begin
					if ({1'b0, mrem} > MaxBody) begin
						err = ST_DECODE; ph = PH_SINK;
					end else begin
						ph = (err != 3'd0) ? PH_DRAIN : PH_VER;
						if (mrem == 24'd0 && ph == PH_VER) begin
							err = ST_DECODE; ph = PH_DRAIN;
						end
					end
				end
			end
			PH_SINK: ;
			default: begin
				if (mrem_q == 24'd0) begin
					err = ST_DECODE; ph = PH_SINK;
				end else begin
					mrem = mr;
					if (!half_q) wsh = b;
					half = !half_q;
					case (ph_q)
						PH_VER: if (wok) begin
							if (w != cfg.version) ph = PH_DRAIN;
							else begin frem = 16'(RANDOM_BYTES); ph = PH_RANDOM; end
						end
						PH_RANDOM: begin
							half = 1'b0; frem = frem_q - 16'd1;
							if (frem == 16'd0) ph = PH_SIDLEN;
						end
						PH_SIDLEN: begin
							half = 1'b0;
							if (b > SID_MAX || 24'(b) > mr) ph = PH_DRAIN;
							else begin
								frem = 16'(b);
								ph = (b != 8'd0) ? PH_SID : PH_CSLEN;
							end
						end
						PH_SID: begin
							half = 1'b0; frem = frem_q - 16'd1;
							if (frem == 16'd0) ph = PH_CSLEN;
						end
						PH_CSLEN: if (wok) begin
							if (24'(w) > mr || w == 16'd0 || w > LIST2_MAX || w[0])
								ph = PH_DRAIN;
							else begin frem = w; ph = PH_CS; end
						end
						PH_CS: begin
							if (frem_q != 16'd0) frem = frem_q - 16'd1;
							if (wok && !got_q[0] && (w == cfg.cipher_a ||
								w == cfg.cipher_b || w == cfg.cipher_c)) begin
								got[0] = 1'b1; pk0 = w;
							end
							if (frem == 16'd0 && half_q) begin
								if (!got[0]) begin err = ST_HS_FAIL; ph = PH_DRAIN; end
								else ph = PH_COMPLEN;
							end
						end
						PH_COMPLEN: begin
							half = 1'b0;
							if (b != 8'd1) ph = PH_DRAIN; else ph = PH_COMPMETH;
						end
						PH_COMPMETH: begin
							half = 1'b0;
							if (b != 8'd0) ph = PH_DRAIN; else ph = PH_EXTLEN;
						end
						PH_EXTLEN: if (wok) begin
							if (24'(w) != mr) ph = PH_DRAIN; else ph = PH_EXTTYPE;
						end
						PH_EXTTYPE: if (wok) begin
							kind = w; ph = PH_EXTDLEN;
						end
						PH_EXTDLEN: if (wok) begin
							if (24'(w) > mr) ph = PH_DRAIN;
							else begin
								erem = w;
								case (kind_q)
									EXT_SERVER_NAME: ph = PH_SN_LLEN;
									EXT_GROUPS, EXT_SIGALGS, EXT_VERSIONS: begin
										if ((got_q & tbit) != 6'd0) ph = PH_DRAIN;
										else ph = (kind_q == EXT_VERSIONS) ?
											PH_LIST_LEN1 : PH_LIST_LEN2;
									end
									EXT_KEY_SHARE: begin
										if (seen_q[0]) ph = PH_DRAIN;
										else begin seen[0] = 1'b1; ph = PH_KS_LEN; end
									end
									EXT_COOKIE: begin
										if (seen_q[1]) ph = PH_DRAIN;
										else begin seen[1] = 1'b1; ph = PH_SKIPEXT; end
									end
									default: ph = PH_SKIPEXT;
								endcase
								if (w == 16'd0 && ph != PH_DRAIN) begin
									if (ph == PH_SKIPEXT) ph = PH_EXTTYPE;
									else ph = PH_DRAIN;
								end
							end
						end
						PH_DRAIN, PH_DONE: half = 1'b0;
						PH_SKIPEXT, PH_SN_LLEN, PH_SN_TYPE, PH_SN_NLEN, PH_SN_NAME,
						PH_LIST_LEN2, PH_LIST_LEN1, PH_LIST_ITEM, PH_KS_LEN,
						PH_KS_GROUP, PH_KS_KLEN, PH_KS_DATA, PH_EXT_END: begin
							erem = erem_q - 16'd1;
							case (ph_q)
								PH_SKIPEXT: half = 1'b0;
								PH_SN_LLEN: if (wok) begin
									if (w != erem || w == 16'd0) ph = PH_DRAIN;
									else ph = PH_SN_TYPE;
								end
								PH_SN_TYPE: begin
									half = 1'b0; irem = 16'(b); ph = PH_SN_NLEN;
								end
								PH_SN_NLEN: if (wok) begin
									if (w > erem) ph = PH_DRAIN;
									else if (irem_q == 16'd0 && got_q[5]) ph = PH_DRAIN;
									else begin
										if (irem_q == 16'd0) begin
											got[5] = 1'b1; sp2 = wp1; sp3 = w;
										end
										frem = w;
										ph = (w != 16'd0) ? PH_SN_NAME : PH_SN_TYPE;
									end
								end
								PH_SN_NAME: begin
									half = 1'b0; frem = frem_q - 16'd1;
									if (frem == 16'd0) ph = PH_SN_TYPE;
								end
								PH_LIST_LEN1, PH_LIST_LEN2: begin
									if (ph_q == PH_LIST_LEN1) begin
										half = 1'b0; wok = 1'b1; w = 16'(b);
									end
									if (wok) begin
										if (w != erem || w == 16'd0 || w[0] ||
											w > ((ph_q == PH_LIST_LEN1) ? LIST1_MAX :
											LIST2_MAX))
											ph = PH_DRAIN;
										else begin irem = w; ph = PH_LIST_ITEM; end
									end
								end
								PH_LIST_ITEM: begin
									if (irem_q != 16'd0) irem = irem_q - 16'd1;
									if (wok && (got_q & tbit) == 6'd0) begin
										case (tgt)
											2'd1: hit = (w == cfg.group);
											2'd2: hit = (w == cfg.sigalg_a ||
												w == cfg.sigalg_b || w == cfg.sigalg_c);
											default: hit = (w == cfg.version);
										endcase
										if (hit) begin
											got = got | tbit;
											if (tgt == 2'd1) pk1 = w;
											if (tgt == 2'd2) pk2 = w;
										end
									end
									if (irem == 16'd0 && half_q) begin
										if ((got & tbit) == 6'd0) begin
											err = (err_q != 3'd0) ? err_q : ST_HS_FAIL;
											ph = PH_DRAIN;
										end else ph = PH_EXT_END;
									end
								end
								PH_KS_LEN: if (wok) begin
									if (w != erem) ph = PH_DRAIN; else ph = PH_KS_GROUP;
								end
								PH_KS_GROUP: if (wok) begin
									irem = w; ph = PH_KS_KLEN;
								end
								PH_KS_KLEN: if (wok) begin
									if (w > erem) ph = PH_DRAIN;
									else begin
										if (!got_q[4] && irem_q == cfg.group) begin
											got[4] = 1'b1; pk3 = irem_q;
											sp0 = wp1; sp1 = w;
										end
										frem = w;
										ph = (w != 16'd0) ? PH_KS_DATA : PH_KS_GROUP;
									end
								end
								PH_KS_DATA: begin
									half = 1'b0; frem = frem_q - 16'd1;
									if (frem == 16'd0) ph = PH_KS_GROUP;
								end
								default: begin half = 1'b0; ph = PH_DRAIN; end
							endcase
							if (ph != PH_DRAIN && erem == 16'd0) begin
								if (ph == PH_SKIPEXT || ph == PH_EXT_END ||
									ph == PH_SN_TYPE || (ph == PH_KS_GROUP && !half))
									ph = PH_EXTTYPE;
								else ph = PH_DRAIN;
							end
						end
						default: begin half = 1'b0; ph = PH_DRAIN; end
					endcase
					if (ph == PH_DRAIN) begin
						half = 1'b0;
						if (err == 3'd0) err = ST_DECODE;
					end
					if (mrem == 24'd0 && ph != PH_DRAIN && ph != PH_DONE) begin
						if (ph != PH_EXTTYPE || half) begin
							ph = PH_DRAIN; half = 1'b0;
							if (err == 3'd0) err = ST_DECODE;
						end else begin
							if (!got[1] || !got[2] || !got[3] || !seen[0] || !seen[1])
								err = ST_MISSING;
							else if (got[4]) err = ST_OK;
							else err = got[1] ? ST_RETRY : ST_HS_FAIL;
							ph = PH_DONE;
						end
					end
				end
			end
		endcase
		pos = wp1;

		if (ph == PH_SINK) status = ST_DECODE;
		else if (ph == PH_TYPE || ph == PH_LEN || mrem != 24'd0) status = ST_RETRY;
		else if (ph == PH_DONE) begin
			status = err; fields = (err <= ST_RETRY);
		end else status = (err != 3'd0) ? err : ST_DECODE;

		result.status        = status;
		result.chosen_cipher = fields ? pk0 : '0;
		result.chosen_group  = fields ? pk1 : '0;
		result.chosen_sigalg = fields ? pk2 : '0;
		result.share_group   = fields ? pk3 : '0;
		result.share_offset  = fields ? sp0 : '0;
		result.share_length  = fields ? sp1 : '0;
		result.name_offset   = fields ? sp2 : '0;
		result.name_length   = fields ? sp3 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_TYPE; pos_q <= '0; mrem_q <= '0; frem_q <= '0; erem_q <= '0;
			irem_q <= '0; kind_q <= '0; wsh_q <= '0; half_q <= 1'b0; seen_q <= '0;
			got_q <= '0; err_q <= '0;
			pk0_q <= '0; pk1_q <= '0; pk2_q <= '0; pk3_q <= '0;
			sp0_q <= '0; sp1_q <= '0; sp2_q <= '0; sp3_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				ph_q <= PH_TYPE; pos_q <= '0; mrem_q <= '0; frem_q <= '0; erem_q <= '0;
				irem_q <= '0; kind_q <= '0; wsh_q <= '0; half_q <= 1'b0; seen_q <= '0;
				got_q <= '0; err_q <= '0;
				pk0_q <= '0; pk1_q <= '0; pk2_q <= '0; pk3_q <= '0;
				sp0_q <= '0; sp1_q <= '0; sp2_q <= '0; sp3_q <= '0;
			end else begin
				ph_q <= ph; pos_q <= pos; mrem_q <= mrem; frem_q <= frem; erem_q <= erem;
				irem_q <= irem; kind_q <= kind; wsh_q <= wsh; half_q <= half;
				seen_q <= seen; got_q <= got; err_q <= err;
				pk0_q <= pk0; pk1_q <= pk1; pk2_q <= pk2; pk3_q <= pk3;
				sp0_q <= sp0; sp1_q <= sp1; sp2_q <= sp2; sp3_q <= sp3;
			end
		end
	end
endmodule
